[rtl/core/qatt_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qatt_pkg
// Shared types, register codes and fixed-point helpers for the attitude
// tracking torque pipeline (signed Q10.22).
// ----------------------------------------------------------------------------
package qatt_pkg;

   localparam int FRAC = 22;
   localparam logic [22:0] ONE_Q = 23'd4194304;
   localparam logic [44:0] ONE_SQ = 45'h1000_0000_0000;
   localparam logic [25:0] INERTIA_FLOOR = 26'd4;
   localparam logic [25:0] INERTIA_RESET = 26'd41943;

   typedef enum logic [2:0] {
      REG_K1         = 3'd0,
      REG_K3         = 3'd1,
      REG_K4         = 3'd2,
      REG_KAPPA      = 3'd3,
      REG_INERTIA_XX = 3'd4,
      REG_INERTIA_YY = 3'd5,
      REG_INERTIA_ZZ = 3'd6
   } reg_idx_type;

   // one request: error vector, body rate, desired rate, desired accel
   typedef struct packed {
      logic [2:0][23:0] e;
      logic [2:0][31:0] w;
      logic [2:0][26:0] wd;
      logic [2:0][30:0] wdd;
   } item_type;

   // after the quadratic terms: squares xx,yy,zz and cross xy,xz,yz
   typedef struct packed {
      item_type         it;
      logic [2:0][47:0] sq;
      logic [2:0][47:0] xp;
   } geo_type;

   // after q0: q0*x, q0*y, q0*z
   typedef struct packed {
      geo_type          g;
      logic [22:0]      q0;
      logic [2:0][47:0] qe;
   } rot_type;

   function automatic logic signed [41:0] rnd_q(input logic signed [63:0] p);
      logic signed [63:0] t;
      t = (p + 64'sd2097152) >>> FRAC;
      return t[41:0];
   endfunction

   function automatic logic signed [41:0] mulq(input logic signed [32:0] a,
                                               input logic signed [32:0] b);
      logic signed [65:0] p;
      p = a * b;
      return rnd_q(p[63:0]);
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
      if (v > 48'sd2147483647) begin
         return 32'sh7FFF_FFFF;
      end else if (v < -48'sd2147483648) begin
         return 32'sh8000_0000;
      end
      return v[31:0];
   endfunction

endpackage
`default_nettype wire

[rtl/core/qatt_sqrt.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qatt_sqrt
// Pipelined floor square root, one result bit per stage, with a sideband
// that travels alongside.
// ----------------------------------------------------------------------------
module qatt_sqrt #(
   parameter int  XW = 46,
   parameter type side_type = logic
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              en,
   input  wire logic              in_valid,
   input  wire logic [XW-1:0]     in_x,
   input  wire side_type          in_side,
   output logic                   out_valid,
   output logic [XW/2-1:0]        out_root,
   output side_type               out_side
);

   localparam int RW = XW / 2;

   logic [RW+1:0] rem_ff  [RW];
   logic [RW-1:0] root_ff [RW];
   logic [XW-1:0] xs_ff   [RW];
   side_type      side_ff [RW];
   logic [RW-1:0] valid_ff;

   for (genvar s = 0; s < RW; s++) begin : g_step
      logic [RW+1:0] rem_prev;
      logic [RW-1:0] root_prev;
      logic [XW-1:0] xs_prev;
      side_type      side_prev;
      logic          v_prev;
      logic [RW+1:0] rem_sh;
      logic [RW+1:0] trial;
      logic [RW+1:0] rem_in;
      logic [RW-1:0] root_in;

      if (s == 0) begin : g_first
         assign rem_prev  = '0;
         assign root_prev = '0;
         assign xs_prev   = in_x;
         assign side_prev = in_side;
         assign v_prev    = in_valid;
      end else begin : g_next
         assign rem_prev  = rem_ff[s-1];
         assign root_prev = root_ff[s-1];
         assign xs_prev   = xs_ff[s-1];
         assign side_prev = side_ff[s-1];
         assign v_prev    = valid_ff[s-1];
      end

      always_comb begin
         rem_sh = {rem_prev[RW-1:0], xs_prev[XW-1 -: 2]};
         trial  = {root_prev, 2'b01};
         if (rem_sh >= trial) begin
            rem_in  = rem_sh - trial;
            root_in = {root_prev[RW-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh;
            root_in = {root_prev[RW-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else if (en) begin
            valid_ff[s] <= v_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[s]  <= rem_in;
            root_ff[s] <= root_in;
            xs_ff[s]   <= {xs_prev[XW-3:0], 2'b00};
            side_ff[s] <= side_prev;
         end
      end
   end

   assign out_valid = valid_ff[RW-1];
   assign out_root  = root_ff[RW-1];
   assign out_side  = side_ff[RW-1];

endmodule
`default_nettype wire

[rtl/core/qatt_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qatt_front
// Request capture, quadratic terms of the error vector and the radicand
// 1 - |e|^2 for the scalar part.
// ----------------------------------------------------------------------------
module qatt_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              en,
   input  wire logic              in_valid,
   input  wire logic [343:0]      in_data,
   output logic                   out_valid,
   output logic [45:0]            out_rad,
   output qatt_pkg::geo_type      out_side
);

   logic [2:0]          v_ff;
   qatt_pkg::item_type  it0_ff;
   qatt_pkg::item_type  it0_in;
   qatt_pkg::geo_type   g1_ff;
   qatt_pkg::geo_type   g1_in;
   qatt_pkg::geo_type   g2_ff;
   logic [45:0]         rad2_ff;
   logic [45:0]         rad2_in;
   logic [46:0]         n2;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         it0_in.e[i]   = in_data[24*i +: 24];
         it0_in.w[i]   = in_data[72 + 32*i +: 32];
         it0_in.wd[i]  = in_data[168 + 27*i +: 27];
         it0_in.wdd[i] = in_data[249 + 31*i +: 31];
      end
   end

   always_comb begin
      g1_in.it = it0_ff;
      for (int i = 0; i < 3; i++) begin
         g1_in.sq[i] = $signed(it0_ff.e[i]) * $signed(it0_ff.e[i]);
      end
      g1_in.xp[0] = $signed(it0_ff.e[0]) * $signed(it0_ff.e[1]);
      g1_in.xp[1] = $signed(it0_ff.e[0]) * $signed(it0_ff.e[2]);
      g1_in.xp[2] = $signed(it0_ff.e[1]) * $signed(it0_ff.e[2]);
   end

   always_comb begin
      n2 = 47'(g1_ff.sq[0]) + 47'(g1_ff.sq[1]) + 47'(g1_ff.sq[2]);
      if (n2 >= 47'(qatt_pkg::ONE_SQ)) begin
         rad2_in = '0;
      end else begin
         rad2_in = 46'(47'(qatt_pkg::ONE_SQ) - n2);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         it0_ff  <= it0_in;
         g1_ff   <= g1_in;
         g2_ff   <= g1_ff;
         rad2_ff <= rad2_in;
      end
   end

   assign out_valid = v_ff[2];
   assign out_rad   = rad2_ff;
   assign out_side  = g2_ff;

endmodule
`default_nettype wire

[rtl/core/qatt_mid.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qatt_mid
// q0 products for the rotation matrix and the radicand (1 - q0) for the
// kappa root.
// ----------------------------------------------------------------------------
module qatt_mid (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              en,
   input  wire logic              in_valid,
   input  wire logic [22:0]       in_q0,
   input  wire qatt_pkg::geo_type in_side,
   output logic                   out_valid,
   output logic [45:0]            out_arg,
   output qatt_pkg::rot_type      out_side
);

   logic                valid_ff;
   qatt_pkg::rot_type   side_ff;
   qatt_pkg::rot_type   side_in;
   logic [45:0]         arg_ff;
   logic [45:0]         arg_in;

   always_comb begin
      side_in.g  = in_side;
      side_in.q0 = in_q0;
      for (int i = 0; i < 3; i++) begin
         side_in.qe[i] = $signed({1'b0, in_q0}) * $signed(in_side.it.e[i]);
      end
      // q0 never exceeds one, so the difference stays non-negative
      arg_in = {1'b0, qatt_pkg::ONE_Q - in_q0, 22'd0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff <= side_in;
         arg_ff  <= arg_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_arg   = arg_ff;
   assign out_side  = side_ff;

endmodule
`default_nettype wire

[rtl/core/qatt_law.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qatt_law
// Rotation matrix, rotated feedforward, gyroscopic and Coriolis terms,
// shaping terms and final torque, ten register stages.
// ----------------------------------------------------------------------------
module qatt_law (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              en,
   input  wire logic              in_valid,
   input  wire logic [22:0]       in_root,
   input  wire qatt_pkg::rot_type in_side,
   input  wire logic [30:0]       gain_k1,
   input  wire logic [30:0]       gain_k3,
   input  wire logic [30:0]       gain_k4,
   input  wire logic [30:0]       gain_kappa,
   input  wire logic [2:0][25:0]  jd,
   output logic                   out_valid,
   output logic [2:0][31:0]       out_torque
);

   logic [9:0] v_ff;

   // stage 1
   logic [2:0][2:0][25:0] r1_ff, r1_in;
   logic [31:0]           kr1_ff, kr1_in;
   logic [2:0][31:0]      jw1_ff, jw1_in;
   logic [2:0][23:0]      e1_ff;
   logic [2:0][31:0]      w1_ff;
   logic [2:0][26:0]      wd1_ff;
   logic [2:0][30:0]      wdd1_ff;
   // stage 2
   logic [2:0][2:0][41:0] ma2_ff, ma2_in, mb2_ff, mb2_in;
   logic [2:0][1:0][41:0] gp2_ff, gp2_in;
   logic [2:0][23:0]      e2_ff;
   logic [2:0][31:0]      w2_ff;
   logic [31:0]           kr2_ff;
   // stage 3
   logic [2:0][31:0]      a3_ff, a3_in, b3_ff, b3_in, gy3_ff, gy3_in;
   logic [2:0][23:0]      e3_ff;
   logic [2:0][31:0]      w3_ff;
   logic [31:0]           kr3_ff;
   // stage 4
   logic [2:0][31:0]      wt4_ff, wt4_in;
   logic [2:0][1:0][41:0] cp4_ff, cp4_in;
   logic [2:0][23:0]      e4_ff;
   logic [2:0][31:0]      b4_ff, gy4_ff;
   logic [31:0]           kr4_ff;
   // stage 5
   logic [2:0][31:0]      cor5_ff, cor5_in, b5_ff, gy5_ff;
   logic [2:0][41:0]      pt5_ff, pt5_in, pk3_5_ff, pk3_5_in;
   logic [2:0][41:0]      pkr5_ff, pkr5_in, pk4_5_ff, pk4_5_in;
   logic [2:0][32:0]      awt;
   // stage 6
   logic [2:0][41:0]      pk1_6_ff, pk1_6_in, pk3_6_ff, pkr6_ff, pk4_6_ff;
   logic [2:0][31:0]      cor6_ff, b6_ff, gy6_ff;
   logic [2:0][31:0]      t1;
   // stage 7
   logic [2:0][31:0]      s7_ff, s7_in, cor7_ff, b7_ff, gy7_ff;
   // stage 8
   logic [2:0][31:0]      u8_ff, u8_in, gy8_ff;
   // stage 9
   logic [2:0][41:0]      pj9_ff, pj9_in;
   logic [2:0][31:0]      gy9_ff;
   // stage 10, output register
   logic [2:0][31:0]      tau_ff, tau_in;

   logic signed [63:0] xx, yy, zz, xy, xz, yz, qx, qy, qz;

   // rotation matrix R = I + 2 q0 [e]x + 2 [e]x^2
   always_comb begin
      xx = 64'($signed(in_side.g.sq[0]));
      yy = 64'($signed(in_side.g.sq[1]));
      zz = 64'($signed(in_side.g.sq[2]));
      xy = 64'($signed(in_side.g.xp[0]));
      xz = 64'($signed(in_side.g.xp[1]));
      yz = 64'($signed(in_side.g.xp[2]));
      qx = 64'($signed(in_side.qe[0]));
      qy = 64'($signed(in_side.qe[1]));
      qz = 64'($signed(in_side.qe[2]));
      r1_in[0][0] = 26'(qatt_pkg::rnd_q(-(2 * (yy + zz))) + 42'(qatt_pkg::ONE_Q));
      r1_in[0][1] = 26'(qatt_pkg::rnd_q(2 * (xy - qz)));
      r1_in[0][2] = 26'(qatt_pkg::rnd_q(2 * (xz + qy)));
      r1_in[1][0] = 26'(qatt_pkg::rnd_q(2 * (xy + qz)));
      r1_in[1][1] = 26'(qatt_pkg::rnd_q(-(2 * (xx + zz))) + 42'(qatt_pkg::ONE_Q));
      r1_in[1][2] = 26'(qatt_pkg::rnd_q(2 * (yz - qx)));
      r1_in[2][0] = 26'(qatt_pkg::rnd_q(2 * (xz - qy)));
      r1_in[2][1] = 26'(qatt_pkg::rnd_q(2 * (yz + qx)));
      r1_in[2][2] = 26'(qatt_pkg::rnd_q(-(2 * (xx + yy))) + 42'(qatt_pkg::ONE_Q));
      kr1_in = qatt_pkg::sat32(48'(qatt_pkg::mulq(33'($signed({1'b0, gain_kappa})),
                                                  33'($signed({1'b0, in_root})))));
      for (int i = 0; i < 3; i++) begin
         jw1_in[i] = qatt_pkg::sat32(48'(qatt_pkg::mulq(33'($signed({1'b0, jd[i]})),
                                     33'($signed(in_side.g.it.w[i])))));
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            ma2_in[i][j] = qatt_pkg::mulq(33'($signed(r1_ff[i][j])),
                                          33'($signed(wd1_ff[j])));
            mb2_in[i][j] = qatt_pkg::mulq(33'($signed(r1_ff[i][j])),
                                          33'($signed(wdd1_ff[j])));
         end
         // w x (J w)
         gp2_in[i][0] = qatt_pkg::mulq(33'($signed(w1_ff[(i+1)%3])),
                                       33'($signed(jw1_ff[(i+2)%3])));
         gp2_in[i][1] = qatt_pkg::mulq(33'($signed(w1_ff[(i+2)%3])),
                                       33'($signed(jw1_ff[(i+1)%3])));
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         a3_in[i]  = qatt_pkg::sat32(48'($signed(ma2_ff[i][0])) + 48'($signed(ma2_ff[i][1]))
                                     + 48'($signed(ma2_ff[i][2])));
         b3_in[i]  = qatt_pkg::sat32(48'($signed(mb2_ff[i][0])) + 48'($signed(mb2_ff[i][1]))
                                     + 48'($signed(mb2_ff[i][2])));
         gy3_in[i] = qatt_pkg::sat32(48'($signed(gp2_ff[i][0])) - 48'($signed(gp2_ff[i][1])));
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         wt4_in[i] = qatt_pkg::sat32(48'($signed(w3_ff[i])) - 48'($signed(a3_ff[i])));
         // (R wd) x w, the negated Coriolis feedforward
         cp4_in[i][0] = qatt_pkg::mulq(33'($signed(a3_ff[(i+1)%3])),
                                       33'($signed(w3_ff[(i+2)%3])));
         cp4_in[i][1] = qatt_pkg::mulq(33'($signed(a3_ff[(i+2)%3])),
                                       33'($signed(w3_ff[(i+1)%3])));
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         cor5_in[i] = qatt_pkg::sat32(48'($signed(cp4_ff[i][0])) - 48'($signed(cp4_ff[i][1])));
         if ($signed(wt4_ff[i]) < 0) begin
            awt[i] = -33'($signed(wt4_ff[i]));
         end else begin
            awt[i] = 33'($signed(wt4_ff[i]));
         end
         pt5_in[i]   = qatt_pkg::mulq($signed(awt[i]), 33'($signed(e4_ff[i])));
         pk3_5_in[i] = qatt_pkg::mulq(33'($signed({1'b0, gain_k3})), 33'($signed(e4_ff[i])));
         pkr5_in[i]  = qatt_pkg::mulq(33'($signed(kr4_ff)), 33'($signed(wt4_ff[i])));
         pk4_5_in[i] = qatt_pkg::mulq(33'($signed({1'b0, gain_k4})),
                                      33'($signed(wt4_ff[i])));
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         t1[i]       = qatt_pkg::sat32(48'($signed(pt5_ff[i])));
         pk1_6_in[i] = qatt_pkg::mulq(33'($signed({1'b0, gain_k1})), 33'($signed(t1[i])));
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         s7_in[i]  = qatt_pkg::sat32(48'($signed(pk1_6_ff[i])) + 48'($signed(pk3_6_ff[i]))
                                     - 48'($signed(pkr6_ff[i])) - 48'($signed(pk4_6_ff[i])));
         u8_in[i]  = qatt_pkg::sat32(48'($signed(cor7_ff[i])) + 48'($signed(b7_ff[i]))
                                     + 48'($signed(s7_ff[i])));
         pj9_in[i] = qatt_pkg::mulq(33'($signed({1'b0, jd[i]})), 33'($signed(u8_ff[i])));
         tau_in[i] = qatt_pkg::sat32(48'($signed(gy9_ff[i])) + 48'($signed(pj9_ff[i])));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[8:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         r1_ff    <= r1_in;
         kr1_ff   <= kr1_in;
         jw1_ff   <= jw1_in;
         e1_ff    <= in_side.g.it.e;
         w1_ff    <= in_side.g.it.w;
         wd1_ff   <= in_side.g.it.wd;
         wdd1_ff  <= in_side.g.it.wdd;

         ma2_ff   <= ma2_in;
         mb2_ff   <= mb2_in;
         gp2_ff   <= gp2_in;
         e2_ff    <= e1_ff;
         w2_ff    <= w1_ff;
         kr2_ff   <= kr1_ff;

         a3_ff    <= a3_in;
         b3_ff    <= b3_in;
         gy3_ff   <= gy3_in;
         e3_ff    <= e2_ff;
         w3_ff    <= w2_ff;
         kr3_ff   <= kr2_ff;

         wt4_ff   <= wt4_in;
         cp4_ff   <= cp4_in;
         e4_ff    <= e3_ff;
         b4_ff    <= b3_ff;
         gy4_ff   <= gy3_ff;
         kr4_ff   <= kr3_ff;

         cor5_ff  <= cor5_in;
         pt5_ff   <= pt5_in;
         pk3_5_ff <= pk3_5_in;
         pkr5_ff  <= pkr5_in;
         pk4_5_ff <= pk4_5_in;
         b5_ff    <= b4_ff;
         gy5_ff   <= gy4_ff;

         pk1_6_ff <= pk1_6_in;
         pk3_6_ff <= pk3_5_ff;
         pkr6_ff  <= pkr5_ff;
         pk4_6_ff <= pk4_5_ff;
         cor6_ff  <= cor5_ff;
         b6_ff    <= b5_ff;
         gy6_ff   <= gy5_ff;

         s7_ff    <= s7_in;
         cor7_ff  <= cor6_ff;
         b7_ff    <= b6_ff;
         gy7_ff   <= gy6_ff;

         u8_ff    <= u8_in;
         gy8_ff   <= gy7_ff;

         pj9_ff   <= pj9_in;
         gy9_ff   <= gy8_ff;

         tau_ff   <= tau_in;
      end
   end

   assign out_valid  = v_ff[9];
   assign out_torque = tau_ff;

   // both roots come from radicands of at most one squared
   a_q0_bound: assert property (@(posedge clock) disable iff (reset)
      in_valid |-> in_side.q0 <= qatt_pkg::ONE_Q)
      else $error("q0 above one");

   a_root_bound: assert property (@(posedge clock) disable iff (reset)
      in_valid |-> in_root <= qatt_pkg::ONE_Q)
      else $error("kappa root above one");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(v_ff))
      else $error("valid bits moved during stall");

endmodule
`default_nettype wire

[rtl/core/quaternion_attitude_tracking_torque.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// quaternion_attitude_tracking_torque
// Attitude tracking torque law on a unit error quaternion, signed Q10.22.
// ----------------------------------------------------------------------------
//  channel  handshake              payload
//  req      req_tvalid/req_tready  req_tdata  344 b: error, rate, ref rate, accel
//  rsp      rsp_tvalid/rsp_tready  rsp_tdata   96 b: torque x, y, z
//  csr      csr_valid/csr_ready    csr_index 3 b, csr_data 32 b
//
//  One request per cycle unless rsp stalls; 3 front stages, 23 + 23 square root
//  digit stages, 1 middle, 10 law stages.
//  The whole pipeline advances together; a result not taken holds every
//  stage and drops req_tready, nothing is lost or repeated.
//  csr is always ready. Reset clears valid bits and loads register defaults.
// ----------------------------------------------------------------------------
module quaternion_attitude_tracking_torque (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   // err_x, err_y, err_z (24), rate_x..z (32), ref_rate_x..z (27),
   // ref_accel_x..z (31), zero pad (2)
   input  wire logic [343:0]  req_tdata,
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   // torque_x, torque_y, torque_z (32 each)
   output logic [95:0]        rsp_tdata,
   input  wire logic          csr_valid,
   output logic               csr_ready,
   input  wire logic [2:0]    csr_index,
   input  wire logic [31:0]   csr_data
);

   logic [30:0] k1_ff, k3_ff, k4_ff, kappa_ff;
   logic [2:0][25:0] inertia_ff;
   logic [2:0][25:0] jd;
   logic en;

   logic              f_valid;
   logic [45:0]       f_rad;
   qatt_pkg::geo_type f_side;
   logic              s1_valid;
   logic [22:0]       s1_root;
   qatt_pkg::geo_type s1_side;
   logic              m_valid;
   logic [45:0]       m_arg;
   qatt_pkg::rot_type m_side;
   logic              s2_valid;
   logic [22:0]       s2_root;
   qatt_pkg::rot_type s2_side;
   logic [2:0][31:0]  torque;

   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en;
   assign csr_ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         k1_ff      <= '0;
         k3_ff      <= '0;
         k4_ff      <= '0;
         kappa_ff   <= '0;
         inertia_ff <= {3{qatt_pkg::INERTIA_RESET}};
      end else if (csr_valid) begin
         unique case (csr_index)
            qatt_pkg::REG_K1:         k1_ff         <= csr_data[30:0];
            qatt_pkg::REG_K3:         k3_ff         <= csr_data[30:0];
            qatt_pkg::REG_K4:         k4_ff         <= csr_data[30:0];
            qatt_pkg::REG_KAPPA:      kappa_ff      <= csr_data[30:0];
            qatt_pkg::REG_INERTIA_XX: inertia_ff[0] <= csr_data[25:0];
            qatt_pkg::REG_INERTIA_YY: inertia_ff[1] <= csr_data[25:0];
            qatt_pkg::REG_INERTIA_ZZ: inertia_ff[2] <= csr_data[25:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         jd[i] = (inertia_ff[i] < qatt_pkg::INERTIA_FLOOR) ? qatt_pkg::INERTIA_FLOOR
                                                           : inertia_ff[i];
      end
   end

   qatt_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_tvalid),
      .in_data   (req_tdata),
      .out_valid (f_valid),
      .out_rad   (f_rad),
      .out_side  (f_side)
   );

   qatt_sqrt #(.XW(46), .side_type(qatt_pkg::geo_type)) u_sqrt_q0 (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (f_valid),
      .in_x      (f_rad),
      .in_side   (f_side),
      .out_valid (s1_valid),
      .out_root  (s1_root),
      .out_side  (s1_side)
   );

   qatt_mid u_mid (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s1_valid),
      .in_q0     (s1_root),
      .in_side   (s1_side),
      .out_valid (m_valid),
      .out_arg   (m_arg),
      .out_side  (m_side)
   );

   qatt_sqrt #(.XW(46), .side_type(qatt_pkg::rot_type)) u_sqrt_root (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (m_valid),
      .in_x      (m_arg),
      .in_side   (m_side),
      .out_valid (s2_valid),
      .out_root  (s2_root),
      .out_side  (s2_side)
   );

   qatt_law u_law (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .in_valid   (s2_valid),
      .in_root    (s2_root),
      .in_side    (s2_side),
      .gain_k1    (k1_ff),
      .gain_k3    (k3_ff),
      .gain_k4    (k4_ff),
      .gain_kappa (kappa_ff),
      .jd         (jd),
      .out_valid  (rsp_tvalid),
      .out_torque (torque)
   );

   assign rsp_tdata = {torque[2], torque[1], torque[0]};

endmodule
`default_nettype wire

[sim/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the attitude tracking torque pipeline: drives
// random and corner requests, predicts each torque triple in Q10.22 and
// compares in order.
// ----------------------------------------------------------------------------
module tb;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [343:0]  req_tdata = '0;
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   logic [95:0]   rsp_tdata;
   logic          csr_valid = 1'b0;
   logic          csr_ready;
   logic [2:0]    csr_index = '0;
   logic [31:0]   csr_data = '0;

   quaternion_attitude_tracking_torque dut (.*);

   initial begin
      forever #10 clock = ~clock;
   end

   // gains and inertia as seen by the predictor
   longint        gain_q [4];
   longint        inertia_q [3];
   logic [95:0]   torque_queue [$];
   int            mismatch_count = 0;
   bit            rsp_stall_on = 1'b1;
   bit            req_idle_on = 1'b1;
   bit            rsp_hold = 1'b0;
   int            idle_cycles = 0;

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("MISMATCH %s: got %0d expected %0d", what, got, want);
      mismatch_count++;
   endtask

   function automatic longint qround(input longint p);
      return (p + 64'sd2097152) >>> qatt_pkg::FRAC;
   endfunction

   function automatic longint qmul(input longint a, input longint b);
      return qround(a * b);
   endfunction

   function automatic longint clip32(input longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint int_root(input longint unsigned x);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b >>= 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return longint'(r);
   endfunction

   function automatic logic [95:0] torque_of(input logic [343:0] d);
      longint e[3], w[3], wd[3], wdd[3], jd[3], a[3], b[3], wt[3], jw[3];
      longint gy[3], co[3], r[3][3];
      longint x, y, z, n2, q0, rt, kr, awt, t1, s, u, tau;
      longint unsigned rad;
      logic [95:0] o;
      for (int i = 0; i < 3; i++) begin
         e[i] = longint'($signed(d[24*i +: 24]));
         w[i] = longint'($signed(d[72 + 32*i +: 32]));
         wd[i] = longint'($signed(d[168 + 27*i +: 27]));
         wdd[i] = longint'($signed(d[249 + 31*i +: 31]));
         jd[i] = inertia_q[i] < 4 ? 4 : inertia_q[i];
      end
      x = e[0]; y = e[1]; z = e[2];
      n2 = x*x + y*y + z*z;
      rad = n2 >= (64'sd1 << 44) ? 0 : longint'((64'sd1 << 44) - n2);
      q0 = int_root(rad);
      r[0][0] = 4194304 + qround(-2*(y*y + z*z));
      r[0][1] = qround(2*(x*y - q0*z));
      r[0][2] = qround(2*(x*z + q0*y));
      r[1][0] = qround(2*(x*y + q0*z));
      r[1][1] = 4194304 + qround(-2*(x*x + z*z));
      r[1][2] = qround(2*(y*z - q0*x));
      r[2][0] = qround(2*(x*z - q0*y));
      r[2][1] = qround(2*(y*z + q0*x));
      r[2][2] = 4194304 + qround(-2*(x*x + y*y));
      for (int i = 0; i < 3; i++) begin
         a[i] = clip32(qmul(r[i][0], wd[0]) + qmul(r[i][1], wd[1]) + qmul(r[i][2], wd[2]));
         b[i] = clip32(qmul(r[i][0], wdd[0]) + qmul(r[i][1], wdd[1])
                       + qmul(r[i][2], wdd[2]));
      end
      for (int i = 0; i < 3; i++) begin
         wt[i] = clip32(w[i] - a[i]);
         jw[i] = clip32(qmul(jd[i], w[i]));
      end
      for (int i = 0; i < 3; i++) begin
         gy[i] = clip32(qmul(w[(i+1)%3], jw[(i+2)%3]) - qmul(w[(i+2)%3], jw[(i+1)%3]));
         co[i] = clip32(qmul(a[(i+1)%3], w[(i+2)%3]) - qmul(a[(i+2)%3], w[(i+1)%3]));
      end
      rt = int_root(longint'(unsigned'(4194304 - q0)) << qatt_pkg::FRAC);
      kr = clip32(qmul(gain_q[qatt_pkg::REG_KAPPA], rt));
      for (int i = 0; i < 3; i++) begin
         awt = wt[i] < 0 ? -wt[i] : wt[i];
         t1 = clip32(qmul(awt, e[i]));
         s = clip32(qmul(gain_q[qatt_pkg::REG_K1], t1) + qmul(gain_q[qatt_pkg::REG_K3], e[i])
                    - qmul(kr, wt[i]) - qmul(gain_q[qatt_pkg::REG_K4], wt[i]));
         u = clip32(co[i] + b[i] + s);
         tau = clip32(gy[i] + qmul(jd[i], u));
         o[32*i +: 32] = tau[31:0];
      end
      return o;
   endfunction

   // watchdog on accepted traffic
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 20000) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // result side: random stall, long hold-off on request
   always @(posedge clock) begin
      if (reset || rsp_hold)
         rsp_tready <= 1'b0;
      else
         rsp_tready <= !rsp_stall_on || ($urandom_range(99) >= 8);
   end

   always @(posedge clock) begin
      logic [95:0] want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (torque_queue.size() == 0) begin
            report_mismatch("unexpected torque", 0, 0);
         end else begin
            want = torque_queue.pop_front();
            for (int i = 0; i < 3; i++)
               if (rsp_tdata[32*i +: 32] !== want[32*i +: 32])
                  report_mismatch($sformatf("torque[%0d]", i),
                                  longint'($signed(rsp_tdata[32*i +: 32])),
                                  longint'($signed(want[32*i +: 32])));
         end
      end
   end

   // tvalid stays up between back-to-back requests; it drops only while idling or draining
   task automatic send_request(input logic [343:0] d);
      if (req_idle_on && $urandom_range(99) < 8) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while (req_idle_on && $urandom_range(99) < 8);
      end
      req_tvalid <= 1'b1;
      req_tdata <= d;
      torque_queue.push_back(torque_of(d));
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic drain_results;
      req_tvalid <= 1'b0;
      while (torque_queue.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   // csr_valid stays up across consecutive writes; the caller drops it
   task automatic write_reg(input qatt_pkg::reg_idx_type idx, input logic [31:0] v);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= v;
      do @(posedge clock); while (!csr_ready);
      if (idx <= qatt_pkg::REG_KAPPA) gain_q[idx] = longint'(v[30:0]);
      else inertia_q[idx - qatt_pkg::REG_INERTIA_XX] = longint'(v[25:0]);
   endtask

   function automatic logic [343:0] pack_item(input longint e[3], input longint w[3],
                                              input longint wd[3], input longint wdd[3]);
      logic [343:0] d;
      d = '0;
      for (int i = 0; i < 3; i++) begin
         d[24*i +: 24] = e[i][23:0];
         d[72 + 32*i +: 32] = w[i][31:0];
         d[168 + 27*i +: 27] = wd[i][26:0];
         d[249 + 31*i +: 31] = wdd[i][30:0];
      end
      return d;
   endfunction

   function automatic longint pick(input longint lo, input longint hi);
      longint unsigned span;
      span = longint'(hi - lo) + 1;
      case ($urandom_range(9))
         0: return lo;
         1: return hi;
         2: return 0;
         default: return lo + longint'(({$urandom, $urandom}) % span);
      endcase
   endfunction

   function automatic logic [343:0] random_item(input bit unit_err);
      longint e[3], w[3], wd[3], wdd[3];
      for (int i = 0; i < 3; i++) begin
         e[i] = pick(-4194304, 4194304);
         if (unit_err) e[i] = e[i] / 2;
         w[i] = $urandom_range(3) == 0 ? pick(-2147483648, 2147483647)
                                      : pick(-41943040, 41943040);
         wd[i] = pick(-41943040, 41943040);
         wdd[i] = pick(-838860800, 838860800);
      end
      return pack_item(e, w, wd, wdd);
   endfunction

   task automatic test_directed;
      longint e[3], w[3], wd[3], wdd[3];
      for (int k = 0; k < 20; k++) begin
         for (int i = 0; i < 3; i++) begin
            e[i] = (k % 4 == 0) ? 0 : (k % 4 == 1) ? 4194304 : (k % 4 == 2) ? -4194304
                   : (i == k % 3 ? 4194304 : 0);
            w[i] = (k % 3 == 0) ? 2147483647 : (k % 3 == 1) ? -2147483648 : 0;
            wd[i] = (k % 2) ? 41943040 : -41943040;
            wdd[i] = (k % 5 < 2) ? 838860800 : -838860800;
         end
         send_request(pack_item(e, w, wd, wdd));
      end
      drain_results();
   endtask

   task automatic test_settings;
      logic [31:0] g;
      for (int ph = 0; ph < 6; ph++) begin
         for (int r = qatt_pkg::REG_K1; r <= qatt_pkg::REG_KAPPA; r++) begin
            g = ph == 0 ? 32'h0 : ph == 1 ? 32'hFFFF_FFFF : $urandom_range(ph * 4194304);
            write_reg(qatt_pkg::reg_idx_type'(r), g);
         end
         for (int r = qatt_pkg::REG_INERTIA_XX; r <= qatt_pkg::REG_INERTIA_ZZ; r++) begin
            g = ph == 0 ? 32'd2 : ph == 1 ? 32'd41943040 : $urandom_range(4, 4194304);
            write_reg(qatt_pkg::reg_idx_type'(r), g);
         end
         csr_valid <= 1'b0;
         req_idle_on = (ph != 3);
         rsp_stall_on = (ph != 3);
         for (int n = 0; n < 180; n++) send_request(random_item($urandom_range(3) != 0));
         drain_results();
      end
      req_idle_on = 1'b1;
      rsp_stall_on = 1'b1;
   endtask

   task automatic test_backpressure;
      fork
         begin
            rsp_hold = 1'b1;
            repeat (300) @(posedge clock);
            rsp_hold = 1'b0;
         end
         for (int n = 0; n < 100; n++) send_request(random_item(1'b1));
      join
      drain_results();
   endtask

   initial begin
      gain_q = '{0, 0, 0, 0};
      inertia_q = '{41943, 41943, 41943};
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_settings();
      test_backpressure();
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

[filelist.f]
rtl/core/qatt_pkg.sv
rtl/core/qatt_sqrt.sv
rtl/core/qatt_front.sv
rtl/core/qatt_mid.sv
rtl/core/qatt_law.sv
rtl/core/quaternion_attitude_tracking_torque.sv
sim/tb.sv
